/* rtl/core/assert_macros.svh */
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every clock edge outside reset.
`define MCSVF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcsvf: implication check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define MCSVF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcsvf: next-cycle check failed");

`else

`define MCSVF_ASSERT_IMP(lbl, ante, cons)
`define MCSVF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/core/mcsvf_pkg.sv */
// Types, constants and arithmetic helpers for the state variable filter.
package mcsvf_pkg;

    localparam int SAMPLE_W = 24;
    localparam int CHAN_W   = 3;
    localparam int COEF_W   = 24;
    localparam int STATE_W  = 32;
    localparam int OP_W     = 33;
    localparam int PROD_W   = COEF_W + 1 + OP_W;
    localparam int Q_SHIFT  = 20;
    localparam int RND_W    = PROD_W - Q_SHIFT;
    localparam int V3_W     = RND_W + 1;
    localparam int SPLIT    = 19;
    localparam int ACC_W    = 64;
    localparam int TERM_W   = ACC_W - Q_SHIFT;
    localparam int SUM_W    = 45;
    localparam int RES_W    = 40;

    localparam logic [COEF_W-1:0] COEF_G_RST  = 24'd68723;
    localparam logic [COEF_W-1:0] COEF_GH_RST = 24'd62400;
    localparam logic [COEF_W-1:0] COEF_K_RST  = 24'd1483144;

    localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(1 << (Q_SHIFT - 1));

    localparam logic signed [SUM_W-1:0] ST_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] ST_MIN = SUM_W'(-64'sd2147483648);
    localparam logic signed [RES_W-1:0] OUT_MAX = RES_W'(64'sd8388607);
    localparam logic signed [RES_W-1:0] OUT_MIN = RES_W'(-64'sd8388608);

    typedef enum logic [1:0] {
        MODE_LOW   = 2'd0,
        MODE_BAND  = 2'd1,
        MODE_HIGH  = 2'd2,
        MODE_NOTCH = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_COEF_G  = 2'd0,
        REG_COEF_GH = 2'd1,
        REG_COEF_K  = 2'd2,
        REG_MODE    = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        MUL_K_MEM,
        MUL_GH_LO,
        MUL_GH_HI,
        MUL_G_BAND,
        MUL_K_BAND
    } mul_sel_t;

    typedef struct packed {
        logic     load_x;
        logic     load_state;
        logic     load_v3;
        logic     load_acc;
        logic     load_band;
        logic     load_low;
        mul_sel_t mul_sel;
    } dp_ctl_t;

    typedef struct packed {
        logic [COEF_W-1:0] g;
        logic [COEF_W-1:0] gh;
        logic [COEF_W-1:0] k;
        mode_t             mode;
    } coef_t;

    function automatic logic signed [RND_W-1:0] round_q20(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + HALF_P;
        return s[PROD_W-1:Q_SHIFT];
    endfunction

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > ST_MAX)
        begin
            r = ST_MAX[STATE_W-1:0];
        end
        else if (v < ST_MIN)
        begin
            r = ST_MIN[STATE_W-1:0];
        end
        else
        begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [RES_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > OUT_MAX)
        begin
            r = OUT_MAX[SAMPLE_W-1:0];
        end
        else if (v < OUT_MIN)
        begin
            r = OUT_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/core/mcsvf_state_mem.sv */
// Per-channel integrator memory with registered read and reset valid bits.
module mcsvf_state_mem
    import mcsvf_pkg::*;
#(
    parameter int DEPTH  = 2,
    parameter int ADDR_W = 1
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic signed [STATE_W-1:0] wr_band,
    input  logic signed [STATE_W-1:0] wr_low,
    output logic signed [STATE_W-1:0] rd_band,
    output logic signed [STATE_W-1:0] rd_low
);

    logic [2*STATE_W-1:0] mem [DEPTH];
    logic [2*STATE_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]     valid_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_band, wr_low};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Treat a never-written entry as zero
    assign rd_band = rd_valid_reg ? $signed(rd_data_reg[2*STATE_W-1:STATE_W]) : '0;
    assign rd_low  = rd_valid_reg ? $signed(rd_data_reg[STATE_W-1:0]) : '0;

endmodule

/* rtl/core/mcsvf_datapath.sv */
// Shared-multiplier datapath: error term, integrator updates and response select.
module mcsvf_datapath
    import mcsvf_pkg::*;
(
    input  logic                       clk,
    input  dp_ctl_t                    ctl,
    input  coef_t                      coef,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [STATE_W-1:0]  mem_band,
    input  logic signed [STATE_W-1:0]  mem_low,
    output logic signed [STATE_W-1:0]  band,
    output logic signed [STATE_W-1:0]  low,
    output logic signed [SAMPLE_W-1:0] result
);

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [STATE_W-1:0]  band_reg;
    logic signed [STATE_W-1:0]  low_reg;
    logic signed [V3_W-1:0]     v3_reg;
    logic signed [PROD_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]   prod_reg;

    logic [COEF_W-1:0]          mul_coef;
    logic signed [OP_W-1:0]     mul_op;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [RND_W-1:0]    prod_rnd;
    logic signed [V3_W-1:0]     v3_next;
    logic signed [ACC_W-1:0]    gh_sum;
    logic signed [TERM_W-1:0]   gh_term;
    logic signed [SUM_W-1:0]    band_sum;
    logic signed [SUM_W-1:0]    low_sum;
    logic signed [RES_W-1:0]    notch;
    logic signed [RES_W-1:0]    res_sel;

    always_comb
    begin
        case (ctl.mul_sel)
            MUL_K_MEM:
            begin
                mul_coef = coef.k;
                mul_op   = OP_W'(mem_band);
            end
            MUL_GH_LO:
            begin
                mul_coef = coef.gh;
                mul_op   = $signed({{(OP_W-SPLIT){1'b0}}, v3_reg[SPLIT-1:0]});
            end
            MUL_GH_HI:
            begin
                mul_coef = coef.gh;
                mul_op   = OP_W'(v3_reg >>> SPLIT);
            end
            MUL_G_BAND:
            begin
                mul_coef = coef.g;
                mul_op   = OP_W'(band_reg);
            end
            MUL_K_BAND:
            begin
                mul_coef = coef.k;
                mul_op   = OP_W'(band_reg);
            end
            default:
            begin
                mul_coef = coef.k;
                mul_op   = '0;
            end
        endcase
    end

    assign prod_next = $signed({1'b0, mul_coef}) * mul_op;
    assign prod_rnd  = round_q20(prod_reg);

    assign v3_next  = V3_W'(x_reg) - V3_W'(low_reg) - V3_W'(prod_rnd);
    // Join the two partial products of gh * v3, then round
    assign gh_sum   = ACC_W'(acc_reg) + (ACC_W'(prod_reg) <<< SPLIT) + ACC_W'(HALF_P);
    assign gh_term  = gh_sum[ACC_W-1:Q_SHIFT];
    assign band_sum = SUM_W'(band_reg) + SUM_W'(gh_term);
    assign low_sum  = SUM_W'(low_reg) + SUM_W'(prod_rnd);

    assign notch = RES_W'(x_reg) - RES_W'(prod_rnd);

    always_comb
    begin
        case (coef.mode)
            MODE_LOW:   res_sel = RES_W'(low_reg);
            MODE_BAND:  res_sel = RES_W'(band_reg);
            MODE_HIGH:  res_sel = notch - RES_W'(low_reg);
            MODE_NOTCH: res_sel = notch;
            default:    res_sel = notch;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctl.load_x)
        begin
            x_reg <= sample;
        end
        if (ctl.load_state)
        begin
            band_reg <= mem_band;
            low_reg  <= mem_low;
        end
        if (ctl.load_v3)
        begin
            v3_reg <= v3_next;
        end
        if (ctl.load_acc)
        begin
            acc_reg <= prod_reg;
        end
        if (ctl.load_band)
        begin
            band_reg <= sat_state(band_sum);
        end
        if (ctl.load_low)
        begin
            low_reg <= sat_state(low_sum);
        end
    end

    assign band   = band_reg;
    assign low    = low_reg;
    assign result = sat_out(res_sel);

endmodule

/* rtl/core/multichannel_state_variable_filter_top.sv */
// Top level of the multichannel state variable filter: sequencer, registers, stream ports.
// A result is offered after LOAD, V3, GH_LO, GH_HI, BAND, G_BAND, LOW and OUT; OUT waits
// while an older result is pending. New input is taken only in IDLE, as the single shared
// multiplier runs five products per sample on a read-modify-write of the state memory.
// Reset: asynchronous; coefficients and mode return to defaults, every channel's
// integrators read as zero through per-entry valid bits, so no clearing pass is needed.
`include "assert_macros.svh"

module multichannel_state_variable_filter_top
    import mcsvf_pkg::*;
#(
    parameter int CHANNELS = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [COEF_W-1:0]   cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SAMPLE_W-1:0] s_axis_tdata,   // [23:0] sample_in
    input  logic [CHAN_W-1:0]   s_axis_tuser,   // [2:0] channel
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [SAMPLE_W-1:0] m_axis_tdata    // [23:0] sample_out
);

    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_V3,
        ST_GH_LO,
        ST_GH_HI,
        ST_BAND,
        ST_G_BAND,
        ST_LOW,
        ST_OUT
    } state_t;

    state_t                     state_reg;
    logic [CH_AW-1:0]           ch_reg;
    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        out_data_reg;
    coef_t                      coef_reg;

    dp_ctl_t                    ctl;
    logic                       in_fire;
    logic                       mem_wr_en;
    logic [CH_AW-1:0]           chan_sel;
    logic signed [STATE_W-1:0]  mem_band;
    logic signed [STATE_W-1:0]  mem_low;
    logic signed [STATE_W-1:0]  dp_band;
    logic signed [STATE_W-1:0]  dp_low;
    logic signed [SAMPLE_W-1:0] dp_result;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign mem_wr_en     = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Fold an out-of-range channel onto channel 0
    assign chan_sel = ({1'b0, s_axis_tuser} < (CHAN_W + 1)'(CHANNELS)) ?
                      s_axis_tuser[CH_AW-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.g    <= COEF_G_RST;
            coef_reg.gh   <= COEF_GH_RST;
            coef_reg.k    <= COEF_K_RST;
            coef_reg.mode <= MODE_LOW;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_COEF_G:  coef_reg.g    <= cfg_wdata;
                REG_COEF_GH: coef_reg.gh   <= cfg_wdata;
                REG_COEF_K:  coef_reg.k    <= cfg_wdata;
                REG_MODE:    coef_reg.mode <= mode_t'(cfg_wdata[1:0]);
            endcase
        end
    end

    always_comb
    begin
        ctl            = '0;
        ctl.mul_sel    = MUL_K_BAND;
        ctl.load_x     = in_fire;
        unique case (state_reg)
            ST_IDLE:   ctl.mul_sel    = MUL_K_BAND;
            ST_LOAD:
            begin
                ctl.mul_sel    = MUL_K_MEM;
                ctl.load_state = 1'b1;
            end
            ST_V3:     ctl.load_v3    = 1'b1;
            ST_GH_LO:  ctl.mul_sel    = MUL_GH_LO;
            ST_GH_HI:
            begin
                ctl.mul_sel    = MUL_GH_HI;
                ctl.load_acc   = 1'b1;
            end
            ST_BAND:   ctl.load_band  = 1'b1;
            ST_G_BAND: ctl.mul_sel    = MUL_G_BAND;
            ST_LOW:
            begin
                ctl.mul_sel    = MUL_K_BAND;
                ctl.load_low   = 1'b1;
            end
            ST_OUT:    ctl.mul_sel    = MUL_K_BAND;
            default:   ctl.mul_sel    = MUL_K_BAND;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && !mem_wr_en)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        ch_reg    <= chan_sel;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:   state_reg <= ST_V3;
                ST_V3:     state_reg <= ST_GH_LO;
                ST_GH_LO:  state_reg <= ST_GH_HI;
                ST_GH_HI:  state_reg <= ST_BAND;
                ST_BAND:   state_reg <= ST_G_BAND;
                ST_G_BAND: state_reg <= ST_LOW;
                ST_LOW:    state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (mem_wr_en)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= dp_result;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    mcsvf_state_mem #(
        .DEPTH  (CHANNELS),
        .ADDR_W (CH_AW)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (chan_sel),
        .wr_en   (mem_wr_en),
        .wr_addr (ch_reg),
        .wr_band (dp_band),
        .wr_low  (dp_low),
        .rd_band (mem_band),
        .rd_low  (mem_low)
    );

    mcsvf_datapath u_datapath (
        .clk      (clk),
        .ctl      (ctl),
        .coef     (coef_reg),
        .sample   ($signed(s_axis_tdata)),
        .mem_band (mem_band),
        .mem_low  (mem_low),
        .band     (dp_band),
        .low      (dp_low),
        .result   (dp_result)
    );

    `MCSVF_ASSERT_NEXT(a_wb_then_out, mem_wr_en, m_axis_tvalid)
    `MCSVF_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready)
    `MCSVF_ASSERT_IMP(a_wb_addr_range, mem_wr_en, ((CH_AW + 1)'(ch_reg) < (CH_AW + 1)'(CHANNELS)))
    `MCSVF_ASSERT_IMP(a_out_from_wb, $rose(m_axis_tvalid), $past(mem_wr_en))

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the multichannel state variable filter stream block.
`timescale 1ns / 100ps

module testbench;
    import mcsvf_pkg::*;

    localparam int N_CHAN         = 2;
    localparam int HOLD_CYCLES    = 300;
    localparam int BLOCK_ITEMS    = 52;
    localparam int PRESSURE_ITEMS = 30;
    localparam int DRAIN_LIMIT    = 20000;
    localparam longint STATE_HI   = 64'sd2147483647;
    localparam longint STATE_LO   = -64'sd2147483648;
    localparam longint OUT_HI     = 64'sd8388607;
    localparam longint OUT_LO     = -64'sd8388608;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        reg_idx_t      idx;
        logic [23:0]   value;
        logic [2:0]    chan;
        logic          typed;
        logic [23:0]   typed_out;
    } step_row_t;

    localparam int N_ROWS = 40;
    localparam step_row_t SCRIPT [N_ROWS] = '{
        '{ROW_ITEM, REG_COEF_G,  24'h000000, 3'd0, 1'b1, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h7FFFFF, 3'd1, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h800000, 3'd0, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h0004D2, 3'd5, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'hFFFFFF, 3'd7, 1'b0, 24'h000000},
        '{ROW_CFG,  REG_MODE,    24'd1,      3'd0, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h7FFFFF, 3'd1, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h800000, 3'd2, 1'b0, 24'h000000},
        '{ROW_CFG,  REG_MODE,    24'd2,      3'd0, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h800000, 3'd0, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h7FFFFF, 3'd6, 1'b0, 24'h000000},
        '{ROW_CFG,  REG_MODE,    24'd3,      3'd0, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h000064, 3'd1, 1'b0, 24'h000000},
        '{ROW_CFG,  REG_COEF_G,  24'h000000, 3'd0, 1'b0, 24'h000000},
        '{ROW_CFG,  REG_COEF_GH, 24'h000000, 3'd0, 1'b0, 24'h000000},
        '{ROW_CFG,  REG_COEF_K,  24'h000000, 3'd0, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h7FFFFF, 3'd1, 1'b1, 24'h7FFFFF},
        '{ROW_ITEM, REG_COEF_G,  24'h800000, 3'd0, 1'b1, 24'h800000},
        '{ROW_ITEM, REG_COEF_G,  24'h000000, 3'd3, 1'b1, 24'h000000},
        '{ROW_CFG,  REG_COEF_G,  24'hFFFFFF, 3'd0, 1'b0, 24'h000000},
        '{ROW_CFG,  REG_COEF_GH, 24'hFFFFFF, 3'd0, 1'b0, 24'h000000},
        '{ROW_CFG,  REG_MODE,    24'd0,      3'd0, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h7FFFFF, 3'd1, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h7FFFFF, 3'd1, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h7FFFFF, 3'd1, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h7FFFFF, 3'd1, 1'b0, 24'h000000},
        '{ROW_CFG,  REG_COEF_K,  24'hFFFFFF, 3'd0, 1'b0, 24'h000000},
        '{ROW_CFG,  REG_MODE,    24'd1,      3'd0, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h800000, 3'd0, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h800000, 3'd0, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h800000, 3'd0, 1'b0, 24'h000000},
        '{ROW_CFG,  REG_MODE,    24'd2,      3'd0, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h7FFFFF, 3'd0, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h800000, 3'd1, 1'b0, 24'h000000},
        '{ROW_CFG,  REG_MODE,    24'd3,      3'd0, 1'b0, 24'h000000},
        '{ROW_ITEM, REG_COEF_G,  24'h7FFFFF, 3'd0, 1'b0, 24'h000000},
        '{ROW_CFG,  REG_COEF_G,  24'd68723,  3'd0, 1'b0, 24'h000000},
        '{ROW_CFG,  REG_COEF_GH, 24'd62400,  3'd0, 1'b0, 24'h000000},
        '{ROW_CFG,  REG_COEF_K,  24'd1483144, 3'd0, 1'b0, 24'h000000},
        '{ROW_CFG,  REG_MODE,    24'd0,      3'd0, 1'b0, 24'h000000}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [1:0]          cfg_index;
    logic [COEF_W-1:0]   cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata;   // [23:0] sample_in
    logic [CHAN_W-1:0]   s_axis_tuser;   // [2:0] channel
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [SAMPLE_W-1:0] m_axis_tdata;   // [23:0] sample_out

    logic [23:0] g_reg;
    logic [23:0] gh_reg;
    logic [23:0] k_reg;
    mode_t       mode_reg;
    longint      band_st [N_CHAN];
    longint      low_st  [N_CHAN];

    logic [23:0] pending_outputs [$];
    int          sample_count;
    int          output_count;
    int          cfg_writes;
    int          error_count;
    int          send_idle_pct;
    int          stall_pct;
    bit          hold_request;

    multichannel_state_variable_filter_top #(
        .CHANNELS(N_CHAN)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #(64'd6_000_000);
        $display("multichannel_state_variable_filter_top test failed");
        $finish;
    end

    function automatic longint q20_mul(input logic [23:0] c, input longint v);
        return (longint'({40'd0, c}) * v + 64'sd524288) >>> 20;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [23:0] next_filter_output(input logic [23:0] smp,
                                                       input logic [2:0] ch);
        longint x;
        longint band;
        longint low;
        longint err;
        longint kb;
        longint resp;
        int     sel;
        x    = longint'($signed(smp));
        sel  = (ch < N_CHAN) ? int'(ch) : 0;
        band = band_st[sel];
        low  = low_st[sel];
        err  = x - low - q20_mul(k_reg, band);
        band = clamp(band + q20_mul(gh_reg, err), STATE_LO, STATE_HI);
        low  = clamp(low + q20_mul(g_reg, band), STATE_LO, STATE_HI);
        band_st[sel] = band;
        low_st[sel]  = low;
        kb = q20_mul(k_reg, band);
        case (mode_reg)
            MODE_LOW:  resp = low;
            MODE_BAND: resp = band;
            MODE_HIGH: resp = x - kb - low;
            default:   resp = x - kb;
        endcase
        resp = clamp(resp, OUT_LO, OUT_HI);
        return resp[23:0];
    endfunction

    function automatic logic [23:0] pick_sample();
        int r;
        r = $urandom_range(9);
        if (r == 0)
        begin
            return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
        end
        else if (r <= 3)
        begin
            return 24'($signed($urandom_range(8191)) - 4096);
        end
        return 24'($urandom);
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        $display("[%0t] ERROR %s", $time, msg);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_COEF_G:  g_reg = val;
            REG_COEF_GH: gh_reg = val;
            REG_COEF_K:  k_reg = val;
            default:     mode_reg = mode_t'(val[1:0]);
        endcase
        cfg_writes++;
    endtask

    task automatic program_filter(input logic [23:0] g, input logic [23:0] gh,
                                  input logic [23:0] k, input mode_t m);
        write_reg(REG_COEF_G, g);
        write_reg(REG_COEF_GH, gh);
        write_reg(REG_COEF_K, k);
        write_reg(REG_MODE, 24'(m));
    endtask

    task automatic send_sample(input logic [23:0] smp, input logic [2:0] ch,
                               input logic typed, input logic [23:0] typed_out);
        logic [23:0] want;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= ch;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        want = next_filter_output(smp, ch);
        pending_outputs.push_back(typed ? typed_out : want);
        sample_count++;
    endtask

    task automatic drain_outputs();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_outputs.size() != 0)
        begin
            flag_error($sformatf("%0d expected outputs never arrived", pending_outputs.size()));
            pending_outputs.delete();
        end
        repeat (2) @(posedge clk);
    endtask

    initial
    begin : output_monitor
        logic [23:0] want;
        int          hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_outputs.size() == 0)
                begin
                    flag_error($sformatf("unexpected output transaction %h", m_axis_tdata));
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    output_count++;
                    if (m_axis_tdata !== want)
                    begin
                        flag_error($sformatf("sample_out %h, expected %h", m_axis_tdata, want));
                    end
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial
    begin : stimulus
        int          i;
        int          p;
        int          b;
        logic [23:0] g;
        logic [23:0] gh;
        logic [23:0] k;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        hold_request  = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        sample_count  = 0;
        output_count  = 0;
        cfg_writes    = 0;
        error_count   = 0;
        g_reg         = COEF_G_RST;
        gh_reg        = COEF_GH_RST;
        k_reg         = COEF_K_RST;
        mode_reg      = MODE_LOW;
        for (i = 0; i < N_CHAN; i++)
        begin
            band_st[i] = 0;
            low_st[i]  = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_ROWS; i++)
        begin
            if (SCRIPT[i].kind == ROW_CFG)
            begin
                drain_outputs();
                write_reg(SCRIPT[i].idx, SCRIPT[i].value);
            end
            else
            begin
                send_sample(SCRIPT[i].value, SCRIPT[i].chan, SCRIPT[i].typed,
                            SCRIPT[i].typed_out);
            end
        end

        for (p = 0; p < 4; p++)
        begin
            send_idle_pct = (p == 1) ? 65 : ((p == 3) ? 15 : 0);
            stall_pct     = (p == 2) ? 65 : ((p == 3) ? 15 : 0);
            for (b = 0; b < 2; b++)
            begin
                drain_outputs();
                if (b == 0)
                begin
                    g  = 24'($urandom_range(400000, 1000));
                    gh = 24'($urandom_range(int'(g)));
                    k  = 24'($urandom_range(4194304));
                end
                else if (p == 1)
                begin
                    g  = 24'hFFFFFF;
                    gh = 24'hFFFFFF;
                    k  = 24'hFFFFFF;
                end
                else if (p == 3)
                begin
                    g  = 24'h000000;
                    gh = 24'h000000;
                    k  = 24'h000000;
                end
                else
                begin
                    g  = 24'($urandom);
                    gh = 24'($urandom);
                    k  = 24'($urandom);
                end
                program_filter(g, gh, k, mode_t'((p * 2 + b) % 4));
                repeat (BLOCK_ITEMS)
                begin
                    send_sample(pick_sample(),
                                ($urandom_range(9) == 0) ? 3'($urandom_range(7, 2))
                                                         : 3'($urandom_range(1)),
                                1'b0, 24'h0);
                end
            end
        end

        drain_outputs();
        send_idle_pct = 0;
        stall_pct     = 0;
        g = 24'($urandom_range(400000, 1000));
        program_filter(g, 24'($urandom_range(int'(g))), 24'($urandom_range(4194304)),
                       mode_t'($urandom_range(3)));
        hold_request = 1'b1;
        repeat (PRESSURE_ITEMS)
        begin
            send_sample(pick_sample(), 3'($urandom_range(7)), 1'b0, 24'h0);
        end

        drain_outputs();
        repeat (16) @(posedge clk);

        $display("Covered %0d samples, %0d outputs checked, %0d register writes;",
                 sample_count, output_count, cfg_writes);
        $display("all four responses, stray channels, saturation and a %0d-cycle output hold.",
                 HOLD_CYCLES);
        if (error_count == 0)
        begin
            $display("multichannel_state_variable_filter_top test passed");
        end
        else
        begin
            $display("multichannel_state_variable_filter_top test failed");
        end
        $finish;
    end

endmodule
